>>> hdl/cmk_pkg.sv
package cmk_pkg;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] ACC_STEPS = 5'd16;
   localparam logic [STEP_W-1:0] KAP_STEPS = 5'd15;

   typedef struct packed {
      logic drop_inc;
      logic pix_rd;
      logic pix_wr;
      logic rpt_init;
      logic rd_row;
      logic rd_col;
      logic cls_emit;
      logic p_add;
      logic k_inc;
      logic mul_nn;
      logic mul_nc;
      logic acc_start;
      logic acc_take;
      logic kap_prep;
      logic kap_start;
      logic sum_emit;
      logic sweep_rst;
      logic clr_wr;
   } cmk_cmd_type;

   typedef struct packed {
      logic pix_drop;
      logic pix_skip;
      logic j_last;
      logic k_last;
      logic div_done;
      logic sweep_last;
   } cmk_sts_type;

   function automatic logic [31:0] inc32(input logic [31:0] a);
      inc32 = (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
   endfunction

endpackage

>>> hdl/cmk_ram.sv
module cmk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cmk_div.sv
module cmk_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                rem0,
   input  logic [63:0]                den,
   input  logic [cmk_pkg::STEP_W-1:0] steps,
   output logic                       done,
   output logic [15:0]                quo
);

   // restoring fraction division, one quotient bit a cycle; rem0 < den
   logic [63:0]                rem_ff, den_ff;
   logic [15:0]                quo_ff;
   logic [cmk_pkg::STEP_W-1:0] cnt_ff;
   logic                       run_ff, done_ff;
   logic [64:0]                r2, diff;
   logic                       ge;

   assign r2   = {rem_ff, 1'b0};
   assign diff = r2 - {1'b0, den_ff};
   assign ge   = r2 >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == cmk_pkg::STEP_W'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem0;
         den_ff <= den;
         quo_ff <= '0;
         cnt_ff <= steps;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[63:0] : r2[63:0];
         quo_ff <= {quo_ff[14:0], ge};
         cnt_ff <= cnt_ff - cmk_pkg::STEP_W'(1);
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> hdl/cmk_datapath.sv
module cmk_datapath #(
   parameter int CLASS_COUNT = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmk_pkg::cmk_cmd_type cmd,
   output cmk_pkg::cmk_sts_type sts,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic [7:0]           req_truth_class,
   input  logic [7:0]           req_classified_class,
   output logic                 rsp_valid,
   output logic                 rsp_is_summary,
   output logic [7:0]           rsp_class_index,
   output logic [31:0]          rsp_correct_count,
   output logic [31:0]          rsp_truth_total,
   output logic [31:0]          rsp_classified_total,
   output logic [31:0]          rsp_total_correct,
   output logic [31:0]          rsp_pixel_count,
   output logic [15:0]          rsp_accuracy_frac,
   output logic signed [15:0]   rsp_kappa_frac,
   output logic [31:0]          rsp_dropped_count,
   output logic                 rsp_last
);

   localparam int CELLS = CLASS_COUNT * CLASS_COUNT;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CLASS_COUNT);
   localparam int RW    = 32 + CW + 1;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
      cell_addr = AW'(r) * AW'(CLASS_COUNT) + AW'(c);
   endfunction

   function automatic logic [31:0] clip32(input logic [RW-1:0] v);
      clip32 = (|v[RW-1:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   logic          excl_ff;
   logic [31:0]   pair_ff, drop_ff;
   logic [CW-1:0] high_ff, hi_ff, k_ff, j_ff, pix_t_ff;
   logic [AW-1:0] sweep_ff, pix_addr_ff;
   logic          tag_row_ff, tag_col_ff, tag_diag_ff;
   logic [RW-1:0] row_ff, col_ff, tc_ff;
   logic [31:0]   diag_ff;
   logic [63:0]   p_ff, mul_ff, nn_ff, den_ff, mag_ff;
   logic          neg_ff, zero_ff, big_ff, q0_ff;
   logic [15:0]   acc_ff;
   logic          valid_ff;

   logic [CW-1:0] t_idx, c_idx;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   rd_data, wr_data;
   logic          wr_en;
   logic [31:0]   row_clip, col_clip, tc_clip, mul_a, mul_b;
   logic [64:0]   p_sum;
   logic          mag_ge, mag_big;
   logic [63:0]   kap_rem0, div_rem0, div_den;
   logic [cmk_pkg::STEP_W-1:0] div_steps;
   logic          div_done;
   logic [15:0]   div_quo;
   logic [16:0]   q17, qn;
   logic [15:0]   kap;

   assign t_idx = req_truth_class[CW-1:0];
   assign c_idx = req_classified_class[CW-1:0];

   assign sts.pix_drop   = (req_truth_class >= 8'(CLASS_COUNT)) ||
                           (req_classified_class >= 8'(CLASS_COUNT));
   assign sts.pix_skip   = excl_ff && (req_truth_class == 8'd0 ||
                                       req_classified_class == 8'd0);
   assign sts.j_last     = j_ff == CW'(CLASS_COUNT - 1);
   assign sts.k_last     = k_ff == hi_ff;
   assign sts.sweep_last = sweep_ff == AW'(CELLS - 1);
   assign sts.div_done   = div_done;

   always_comb begin
      priority if (cmd.pix_rd) begin
         rd_addr = cell_addr(t_idx, c_idx);
      end else if (cmd.rd_row) begin
         rd_addr = cell_addr(k_ff, j_ff);
      end else begin
         rd_addr = cell_addr(j_ff, k_ff);
      end
   end

   assign wr_en   = cmd.clr_wr | cmd.pix_wr;
   assign wr_addr = cmd.clr_wr ? sweep_ff : pix_addr_ff;
   assign wr_data = cmd.clr_wr ? 32'd0 : cmk_pkg::inc32(rd_data);

   cmk_ram #(.WIDTH(32), .DEPTH(CELLS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign row_clip = clip32(row_ff);
   assign col_clip = clip32(col_ff);
   assign tc_clip  = clip32(tc_ff);

   always_comb begin
      priority if (cmd.cls_emit) begin
         mul_a = row_clip;
         mul_b = col_clip;
      end else if (cmd.mul_nn) begin
         mul_a = pair_ff;
         mul_b = pair_ff;
      end else begin
         mul_a = pair_ff;
         mul_b = tc_clip;
      end
   end

   assign p_sum    = {1'b0, p_ff} + {1'b0, mul_ff};
   assign mag_ge   = mag_ff >= den_ff;
   assign mag_big  = {1'b0, mag_ff} >= {den_ff, 1'b0};
   assign kap_rem0 = mag_ge ? mag_ff - den_ff : mag_ff;

   assign div_rem0  = cmd.acc_start ? {32'd0, tc_clip} : kap_rem0;
   assign div_den   = cmd.acc_start ? {32'd0, pair_ff} : den_ff;
   assign div_steps = cmd.acc_start ? cmk_pkg::ACC_STEPS : cmk_pkg::KAP_STEPS;

   cmk_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.acc_start | cmd.kap_start),
      .rem0  (div_rem0),
      .den   (div_den),
      .steps (div_steps),
      .done  (div_done),
      .quo   (div_quo)
   );

   // quotient of two or more saturates either way
   assign q17 = big_ff ? 17'h1_0000 : {1'b0, q0_ff, div_quo[14:0]};
   assign qn  = (q17 > 17'd32768) ? 17'd32768 : q17;
   always_comb begin
      priority if (zero_ff) begin
         kap = 16'd0;
      end else if (neg_ff) begin
         kap = 16'(17'h1_0000 - qn);
      end else if (q17 > 17'd32767) begin
         kap = 16'd32767;
      end else begin
         kap = q17[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         excl_ff     <= 1'b0;
         pair_ff     <= '0;
         drop_ff     <= '0;
         high_ff     <= '0;
         sweep_ff    <= '0;
         tag_row_ff  <= 1'b0;
         tag_col_ff  <= 1'b0;
         tag_diag_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            excl_ff <= csr_wdata;
         end
         if (cmd.drop_inc) begin
            drop_ff <= cmk_pkg::inc32(drop_ff);
         end
         if (cmd.pix_wr) begin
            pair_ff <= cmk_pkg::inc32(pair_ff);
            if (pix_t_ff > high_ff) begin
               high_ff <= pix_t_ff;
            end
         end
         if (cmd.sum_emit) begin
            pair_ff <= '0;
            drop_ff <= '0;
            high_ff <= '0;
         end
         if (cmd.sweep_rst) begin
            sweep_ff <= '0;
         end else if (cmd.clr_wr) begin
            sweep_ff <= sweep_ff + AW'(1);
         end
         tag_row_ff  <= cmd.rd_row;
         tag_col_ff  <= cmd.rd_col;
         tag_diag_ff <= cmd.rd_row && (j_ff == k_ff);
         valid_ff    <= cmd.cls_emit | cmd.sum_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_rd) begin
         pix_addr_ff <= cell_addr(t_idx, c_idx);
         pix_t_ff    <= t_idx;
      end
      if (cmd.rpt_init) begin
         k_ff   <= CW'(excl_ff);
         hi_ff  <= (high_ff > CW'(excl_ff)) ? high_ff : CW'(excl_ff);
         j_ff   <= '0;
         row_ff <= '0;
         col_ff <= '0;
         tc_ff  <= '0;
         p_ff   <= '0;
      end
      if (cmd.rd_row || cmd.rd_col) begin
         j_ff <= sts.j_last ? '0 : j_ff + CW'(1);
      end
      if (tag_row_ff) begin
         row_ff <= row_ff + RW'(rd_data);
      end
      if (tag_col_ff) begin
         col_ff <= col_ff + RW'(rd_data);
      end
      if (tag_diag_ff) begin
         diag_ff <= rd_data;
      end
      if (cmd.cls_emit || cmd.mul_nn || cmd.mul_nc) begin
         mul_ff <= 64'(mul_a) * 64'(mul_b);
      end
      if (cmd.cls_emit) begin
         tc_ff <= tc_ff + RW'(diag_ff);
      end
      if (cmd.p_add) begin
         p_ff   <= p_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : p_sum[63:0];
         row_ff <= '0;
         col_ff <= '0;
      end
      if (cmd.k_inc) begin
         k_ff <= k_ff + CW'(1);
      end
      if (cmd.mul_nc) begin
         nn_ff <= mul_ff;
      end
      if (cmd.acc_take) begin
         if (pair_ff == 32'd0) begin
            acc_ff <= 16'd0;
         end else if (tc_clip >= pair_ff) begin
            acc_ff <= 16'hFFFF;
         end else begin
            acc_ff <= div_quo;
         end
      end
      if (cmd.kap_prep) begin
         den_ff  <= nn_ff - p_ff;
         zero_ff <= nn_ff <= p_ff;
         neg_ff  <= mul_ff < p_ff;
         mag_ff  <= (mul_ff < p_ff) ? p_ff - mul_ff : mul_ff - p_ff;
      end
      if (cmd.kap_start) begin
         q0_ff  <= mag_ge;
         big_ff <= mag_big;
      end
      if (cmd.cls_emit) begin
         rsp_is_summary       <= 1'b0;
         rsp_class_index      <= 8'(k_ff);
         rsp_correct_count    <= diag_ff;
         rsp_truth_total      <= row_clip;
         rsp_classified_total <= col_clip;
         rsp_total_correct    <= '0;
         rsp_pixel_count      <= '0;
         rsp_accuracy_frac    <= '0;
         rsp_kappa_frac       <= '0;
         rsp_dropped_count    <= '0;
         rsp_last             <= 1'b0;
      end else if (cmd.sum_emit) begin
         rsp_is_summary       <= 1'b1;
         rsp_class_index      <= '0;
         rsp_correct_count    <= '0;
         rsp_truth_total      <= '0;
         rsp_classified_total <= '0;
         rsp_total_correct    <= tc_clip;
         rsp_pixel_count      <= pair_ff;
         rsp_accuracy_frac    <= acc_ff;
         rsp_kappa_frac       <= kap;
         rsp_dropped_count    <= drop_ff;
         rsp_last             <= 1'b1;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

>>> hdl/cmk_ctrl.sv
module cmk_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_type,
   input  cmk_pkg::cmk_sts_type sts,
   output cmk_pkg::cmk_cmd_type cmd,
   output logic                 busy
);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_PIX  = 4'd2;
   localparam logic [3:0] S_ROW  = 4'd3;
   localparam logic [3:0] S_COL  = 4'd4;
   localparam logic [3:0] S_WAIT = 4'd5;
   localparam logic [3:0] S_CLS  = 4'd6;
   localparam logic [3:0] S_PADD = 4'd7;
   localparam logic [3:0] S_NN   = 4'd8;
   localparam logic [3:0] S_NC   = 4'd9;
   localparam logic [3:0] S_DIVA = 4'd10;
   localparam logic [3:0] S_KPRE = 4'd11;
   localparam logic [3:0] S_KST  = 4'd12;
   localparam logic [3:0] S_DIVK = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (req_type) begin
                  cmd.rpt_init = 1'b1;
                  state_in     = S_ROW;
               end else if (sts.pix_drop) begin
                  cmd.drop_inc = 1'b1;
               end else if (!sts.pix_skip) begin
                  cmd.pix_rd = 1'b1;
                  state_in   = S_PIX;
               end
            end
         end
         S_PIX: begin
            cmd.pix_wr = 1'b1;
            state_in   = S_IDLE;
         end
         S_ROW: begin
            cmd.rd_row = 1'b1;
            if (sts.j_last) state_in = S_COL;
         end
         S_COL: begin
            cmd.rd_col = 1'b1;
            if (sts.j_last) state_in = S_WAIT;
         end
         S_WAIT: state_in = S_CLS;
         S_CLS: begin
            cmd.cls_emit = 1'b1;
            state_in     = S_PADD;
         end
         S_PADD: begin
            cmd.p_add = 1'b1;
            if (sts.k_last) begin
               state_in = S_NN;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_ROW;
            end
         end
         S_NN: begin
            cmd.mul_nn    = 1'b1;
            cmd.acc_start = 1'b1;
            state_in      = S_NC;
         end
         S_NC: begin
            cmd.mul_nc = 1'b1;
            state_in   = S_DIVA;
         end
         S_DIVA: begin
            if (sts.div_done) begin
               cmd.acc_take = 1'b1;
               state_in     = S_KPRE;
            end
         end
         S_KPRE: begin
            cmd.kap_prep = 1'b1;
            state_in     = S_KST;
         end
         S_KST: begin
            cmd.kap_start = 1'b1;
            state_in      = S_DIVK;
         end
         S_DIVK: begin
            if (sts.div_done) begin
               cmd.sum_emit  = 1'b1;
               cmd.sweep_rst = 1'b1;
               state_in      = S_CLR;
            end
         end
         default: state_in = S_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

>>> hdl/confusion_matrix_kappa_core.sv
// channel        ports                                        handshake
// request        req_type, req_truth_class, req_classified_class  start & !busy
// response       rsp_* fields                                 rsp_valid, one cycle
// config         csr_wdata                                    csr_we
//
// Pixel pair: a read-modify-write of one store cell (read in S_IDLE, write in S_PIX);
// dropped or excluded pairs are handled in S_IDLE alone. Finish: per reported class a row
// walk then a column walk through the read port, then the accuracy and kappa
// divisions, then the store is cleared one cell at a time.
// After reset the store is cleared the same way, with busy high throughout.
// Responses cannot be held off; each is shown for exactly one cycle.
module confusion_matrix_kappa_core #(
   parameter int CLASS_COUNT = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [7:0]         req_truth_class,
   input  logic [7:0]         req_classified_class,
   input  logic               csr_we,
   input  logic               csr_wdata,
   output logic               rsp_valid,
   output logic               rsp_is_summary,
   output logic [7:0]         rsp_class_index,
   output logic [31:0]        rsp_correct_count,
   output logic [31:0]        rsp_truth_total,
   output logic [31:0]        rsp_classified_total,
   output logic [31:0]        rsp_total_correct,
   output logic [31:0]        rsp_pixel_count,
   output logic [15:0]        rsp_accuracy_frac,
   output logic signed [15:0] rsp_kappa_frac,
   output logic [31:0]        rsp_dropped_count,
   output logic               rsp_last
);

   cmk_pkg::cmk_cmd_type cmd;
   cmk_pkg::cmk_sts_type sts;

   cmk_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   cmk_datapath #(.CLASS_COUNT(CLASS_COUNT)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .req_truth_class      (req_truth_class),
      .req_classified_class (req_classified_class),
      .rsp_valid            (rsp_valid),
      .rsp_is_summary       (rsp_is_summary),
      .rsp_class_index      (rsp_class_index),
      .rsp_correct_count    (rsp_correct_count),
      .rsp_truth_total      (rsp_truth_total),
      .rsp_classified_total (rsp_classified_total),
      .rsp_total_correct    (rsp_total_correct),
      .rsp_pixel_count      (rsp_pixel_count),
      .rsp_accuracy_frac    (rsp_accuracy_frac),
      .rsp_kappa_frac       (rsp_kappa_frac),
      .rsp_dropped_count    (rsp_dropped_count),
      .rsp_last             (rsp_last)
   );

   // results only come out of a report run
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside a report run");

   a_last_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> rsp_is_summary)
      else $error("last flag on a non-summary transaction");

   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type) |=> busy)
      else $error("finish transaction did not start a report");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> busy)
      else $error("store clear not started after reset");

endmodule

>>> tb/sv/confusion_matrix_kappa_core_tb.sv
`timescale 1ns / 100ps

module confusion_matrix_kappa_core_tb;

   localparam int NCLS = 32;
   localparam logic PIXEL = 1'b0;
   localparam logic FINISH = 1'b1;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic        is_summary;
      logic [7:0]  class_index;
      logic [31:0] correct_count;
      logic [31:0] truth_total;
      logic [31:0] classified_total;
      logic [31:0] total_correct;
      logic [31:0] pixel_count;
      logic [15:0] accuracy_frac;
      logic [15:0] kappa_frac;
      logic [31:0] dropped_count;
      logic        last;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = 1'b0;
   logic [7:0]  req_truth_class = '0;
   logic [7:0]  req_classified_class = '0;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        rsp_valid;
   logic        rsp_is_summary;
   logic [7:0]  rsp_class_index;
   logic [31:0] rsp_correct_count;
   logic [31:0] rsp_truth_total;
   logic [31:0] rsp_classified_total;
   logic [31:0] rsp_total_correct;
   logic [31:0] rsp_pixel_count;
   logic [15:0] rsp_accuracy_frac;
   logic signed [15:0] rsp_kappa_frac;
   logic [31:0] rsp_dropped_count;
   logic        rsp_last;

   int errors = 0;
   int cycles = 0;
   int n_pix = 0;
   int n_fin = 0;
   int n_res = 0;
   int idle_pct = 33;

   always #2 clock = ~clock;

   confusion_matrix_kappa_core #(.CLASS_COUNT(NCLS)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_truth_class(req_truth_class),
      .req_classified_class(req_classified_class),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_is_summary(rsp_is_summary),
      .rsp_class_index(rsp_class_index), .rsp_correct_count(rsp_correct_count),
      .rsp_truth_total(rsp_truth_total), .rsp_classified_total(rsp_classified_total),
      .rsp_total_correct(rsp_total_correct), .rsp_pixel_count(rsp_pixel_count),
      .rsp_accuracy_frac(rsp_accuracy_frac), .rsp_kappa_frac(rsp_kappa_frac),
      .rsp_dropped_count(rsp_dropped_count), .rsp_last(rsp_last)
   );

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp);
      errors++;
      $display("MISMATCH %s: got %0h expected %0h", what, got, exp);
   endtask

   class scoreboard_type;
      logic [31:0] cells[NCLS*NCLS];
      logic [7:0]  top_truth;
      logic [31:0] pairs;
      logic [31:0] drops;
      logic        exclude;
      report_type  pending[$];

      function void clear();
         foreach (cells[i]) cells[i] = '0;
         top_truth = '0;
         pairs = '0;
         drops = '0;
      endfunction

      function logic [31:0] sat_inc(logic [31:0] a);
         return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
      endfunction

      function logic [15:0] kappa(logic [63:0] n, logic [63:0] c, logic [63:0] p);
         logic [63:0] nn, nc, den, mag, q, rem;
         logic neg;
         nn = n * n;
         nc = n * c;
         if (nn <= p) return 16'd0;
         den = nn - p;
         neg = nc < p;
         mag = neg ? p - nc : nc - p;
         q = mag / den;
         rem = mag % den;
         if (q >= 2) q = 65536;
         else begin
            for (int b = 0; b < 15; b++) begin
               q = q << 1;
               if (rem >= den - rem) begin
                  rem = rem - (den - rem);
                  q = q | 1;
               end else begin
                  rem = rem << 1;
               end
            end
         end
         if (neg) begin
            if (q > 32768) q = 32768;
            return 16'(64'h10000 - q);
         end
         if (q > 32767) q = 32767;
         return q[15:0];
      endfunction

      function void note_request(logic typ, logic [7:0] t, logic [7:0] c);
         report_type r;
         int first, hi;
         logic [63:0] row, col, tc, prod, term, acc;
         if (typ == PIXEL) begin
            if (t >= NCLS || c >= NCLS) drops = sat_inc(drops);
            else if (!(exclude && (t == 0 || c == 0))) begin
               cells[t*NCLS+c] = sat_inc(cells[t*NCLS+c]);
               pairs = sat_inc(pairs);
               if (t > top_truth) top_truth = t;
            end
            return;
         end
         first = exclude;
         hi = (top_truth < first) ? first : top_truth;
         tc = 0;
         prod = 0;
         for (int k = first; k <= hi && k < NCLS; k++) begin
            row = 0;
            col = 0;
            for (int j = 0; j < NCLS; j++) begin
               row += cells[k*NCLS+j];
               col += cells[j*NCLS+k];
            end
            if (row > 64'hFFFF_FFFF) row = 64'hFFFF_FFFF;
            if (col > 64'hFFFF_FFFF) col = 64'hFFFF_FFFF;
            tc += cells[k*NCLS+k];
            term = row * col;
            prod = (prod > ~64'd0 - term) ? ~64'd0 : prod + term;
            r = '{default: '0};
            r.class_index = 8'(k);
            r.correct_count = cells[k*NCLS+k];
            r.truth_total = row[31:0];
            r.classified_total = col[31:0];
            pending.push_back(r);
         end
         if (tc > 64'hFFFF_FFFF) tc = 64'hFFFF_FFFF;
         acc = 0;
         if (pairs != 0) begin
            acc = (tc << 16) / pairs;
            if (acc > 65535) acc = 65535;
         end
         r = '{default: '0};
         r.is_summary = 1'b1;
         r.total_correct = tc[31:0];
         r.pixel_count = pairs;
         r.accuracy_frac = acc[15:0];
         r.kappa_frac = kappa(64'(pairs), tc, prod);
         r.dropped_count = drops;
         r.last = 1'b1;
         pending.push_back(r);
         clear();
      endfunction

      task check_result(report_type got);
         report_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
            return;
         end
         e = pending.pop_front();
         if (got.is_summary !== e.is_summary)
            report_mismatch("is_summary", got.is_summary, e.is_summary);
         if (got.class_index !== e.class_index)
            report_mismatch("class_index", got.class_index, e.class_index);
         if (got.correct_count !== e.correct_count)
            report_mismatch("correct_count", got.correct_count, e.correct_count);
         if (got.truth_total !== e.truth_total)
            report_mismatch("truth_total", got.truth_total, e.truth_total);
         if (got.classified_total !== e.classified_total)
            report_mismatch("classified_total", got.classified_total, e.classified_total);
         if (got.total_correct !== e.total_correct)
            report_mismatch("total_correct", got.total_correct, e.total_correct);
         if (got.pixel_count !== e.pixel_count)
            report_mismatch("pixel_count", got.pixel_count, e.pixel_count);
         if (got.accuracy_frac !== e.accuracy_frac)
            report_mismatch("accuracy_frac", got.accuracy_frac, e.accuracy_frac);
         if (got.kappa_frac !== e.kappa_frac)
            report_mismatch("kappa_frac", got.kappa_frac, e.kappa_frac);
         if (got.dropped_count !== e.dropped_count)
            report_mismatch("dropped_count", got.dropped_count, e.dropped_count);
         if (got.last !== e.last)
            report_mismatch("last", got.last, e.last);
      endtask
   endclass

   scoreboard_type matrix_sb;

   always @(posedge clock) begin
      report_type r;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         r.is_summary = rsp_is_summary;
         r.class_index = rsp_class_index;
         r.correct_count = rsp_correct_count;
         r.truth_total = rsp_truth_total;
         r.classified_total = rsp_classified_total;
         r.total_correct = rsp_total_correct;
         r.pixel_count = rsp_pixel_count;
         r.accuracy_frac = rsp_accuracy_frac;
         r.kappa_frac = rsp_kappa_frac;
         r.dropped_count = rsp_dropped_count;
         r.last = rsp_last;
         matrix_sb.check_result(r);
         n_res++;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** confusion_matrix_kappa_core: FAILED **");
         $finish;
      end
   end

   // one transaction: optional idle, then hold start until accepted;
   // start is dropped by the next idle cycle or by drain
   task automatic send(input logic typ, input logic [7:0] t, input logic [7:0] c);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_type <= typ;
      req_truth_class <= t;
      req_classified_class <= c;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      matrix_sb.note_request(typ, t, c);
      if (typ == PIXEL) n_pix++;
      else n_fin++;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (matrix_sb.pending.size() != 0) @(negedge clock);
      repeat (NCLS * NCLS + 100) @(negedge clock);
   endtask

   task automatic write_exclude(input logic v);
      drain();
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      matrix_sb.exclude = v;
   endtask

   // mostly in-range labels, a few out of range or with high bits
   function automatic logic [7:0] rand_label();
      int s;
      s = $urandom_range(99);
      if (s < 80) return 8'($urandom_range(NCLS - 1));
      if (s < 88) return 8'd0;
      return 8'($urandom_range(255));
   endfunction

   task automatic random_run(input int n, input int span);
      logic [7:0] t;
      for (int i = 0; i < n; i++) begin
         t = rand_label();
         if (t < NCLS && span < NCLS) t = 8'(t % span);
         // bias towards the diagonal so kappa ends up positive too
         send(PIXEL, t, ($urandom_range(1)) ? t : rand_label());
      end
      send(FINISH, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   initial begin
      matrix_sb = new();
      matrix_sb.clear();
      matrix_sb.exclude = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty report, extremes, drops, all classes
      send(FINISH, 8'h00, 8'h00);
      send(PIXEL, 8'd0, 8'd0);
      send(PIXEL, 8'd31, 8'd31);
      send(PIXEL, 8'd31, 8'd0);
      send(PIXEL, 8'd32, 8'd1);
      send(PIXEL, 8'd1, 8'd32);
      send(PIXEL, 8'd255, 8'd255);
      send(FINISH, 8'hFF, 8'hFF);
      send(PIXEL, 8'd3, 8'd5);
      send(PIXEL, 8'd5, 8'd3);
      send(FINISH, 8'h00, 8'h00);
      send(PIXEL, 8'd2, 8'd2);
      send(FINISH, 8'h00, 8'h00);
      write_exclude(1'b1);
      send(FINISH, 8'h00, 8'h00);
      send(PIXEL, 8'd0, 8'd4);
      send(PIXEL, 8'd4, 8'd0);
      send(PIXEL, 8'd40, 8'd0);
      send(FINISH, 8'h00, 8'h00);
      send(PIXEL, 8'd1, 8'd1);
      send(PIXEL, 8'd7, 8'd2);
      send(FINISH, 8'h00, 8'h00);

      idle_pct = 0;
      random_run(40, NCLS);
      idle_pct = 33;
      random_run(30, 4);
      write_exclude(1'b0);
      random_run(50, NCLS);
      random_run(25, 3);
      write_exclude(1'b1);
      random_run(40, NCLS);
      random_run(10, 2);

      drain();
      $display("%0d pixel pairs and %0d reports sent, %0d results checked",
               n_pix, n_fin, n_res);
      $display("covered both exclude settings, label drops and empty reports");
      if (errors == 0 && matrix_sb.pending.size() == 0)
         $display("** confusion_matrix_kappa_core: PASSED **");
      else
         $display("** confusion_matrix_kappa_core: FAILED **");
      $finish;
   end

endmodule
